// ===== rtl/clt_pkg.sv =====
`default_nettype none

package clt_pkg;

    localparam int LINE_LIMIT  = 64;
    localparam int MAX_PARAMS  = 4;
    localparam int TOKEN_CHARS = 9;

    // Fixed by the result ports
    localparam int NUM_OUT   = 4;
    localparam int PARAM_W   = 31;
    // Nine decimal digits always fit in 30 bits
    localparam int VAL_W     = 30;
    localparam int POS_W     = $clog2(LINE_LIMIT);
    localparam int CNT_W     = $clog2(MAX_PARAMS + 1);
    localparam int TLEN_W    = 4;
    localparam int QDEPTH    = 2;
    localparam int QPTR_W    = $clog2(QDEPTH);
    localparam int QCNT_W    = $clog2(QDEPTH + 1);

    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_VT    = 8'd11;
    localparam logic [7:0] CH_FF    = 8'd12;
    localparam logic [7:0] CH_PLUS  = 8'd43;
    localparam logic [7:0] CH_MINUS = 8'd45;
    localparam logic [7:0] CH_ZERO  = 8'd48;
    localparam logic [7:0] CH_NINE  = 8'd57;

    typedef enum logic [2:0] {
        CLS_LF,
        CLS_CR,
        CLS_SPACE,
        CLS_DIGIT,
        CLS_PLUS,
        CLS_MINUS,
        CLS_BLANK,
        CLS_OTHER
    } char_class_t;

    typedef struct packed {
        char_class_t cls;
        logic [7:0]  ch;
    } q_entry_t;

endpackage

`default_nettype wire

// ===== rtl/clt_front.sv =====
`default_nettype none

module clt_front (
    input  wire logic              rx_valid,
    output logic                   rx_stall,
    input  wire logic [7:0]        rx_byte,
    output logic                   push,
    output clt_pkg::q_entry_t      push_entry,
    input  wire logic              q_full
);
    import clt_pkg::*;

    assign rx_stall = q_full;
    assign push     = rx_valid && !q_full;

    always_comb
    begin
        push_entry.ch = rx_byte;
        if (rx_byte == CH_LF)
            push_entry.cls = CLS_LF;
        else if (rx_byte == CH_CR)
            push_entry.cls = CLS_CR;
        else if (rx_byte == CH_SPACE)
            push_entry.cls = CLS_SPACE;
        else if (rx_byte >= CH_ZERO && rx_byte <= CH_NINE)
            push_entry.cls = CLS_DIGIT;
        else if (rx_byte == CH_PLUS)
            push_entry.cls = CLS_PLUS;
        else if (rx_byte == CH_MINUS)
            push_entry.cls = CLS_MINUS;
        else if (rx_byte == CH_TAB || rx_byte == CH_VT || rx_byte == CH_FF)
            push_entry.cls = CLS_BLANK;
        else
            push_entry.cls = CLS_OTHER;
    end

endmodule

`default_nettype wire

// ===== rtl/clt_queue.sv =====
`default_nettype none

module clt_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  clt_pkg::q_entry_t      push_entry,
    output logic                   full,
    input  wire logic              pop,
    output logic                   q_valid,
    output clt_pkg::q_entry_t      q_head
);
    import clt_pkg::*;

    q_entry_t            mem_reg [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]   cnt_reg, cnt_next;

    assign full    = (cnt_reg == QCNT_W'(QDEPTH));
    assign q_valid = (cnt_reg != '0);
    assign q_head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_entry;
    end

endmodule

`default_nettype wire

// ===== rtl/clt_back.sv =====
`default_nettype none

module clt_back (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      q_valid,
    input  clt_pkg::q_entry_t              q_head,
    output logic                           pop,
    output logic                           res_valid,
    input  wire logic                      res_stall,
    output logic [15:0]                    command_code,
    output logic [2:0]                     param_count,
    output logic signed [clt_pkg::PARAM_W-1:0] param_a,
    output logic signed [clt_pkg::PARAM_W-1:0] param_b,
    output logic signed [clt_pkg::PARAM_W-1:0] param_c,
    output logic signed [clt_pkg::PARAM_W-1:0] param_d
);
    import clt_pkg::*;

    localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_LIMIT - 1);

    // Line and token state
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic               stopped_reg, stopped_next;
    logic [15:0]        code_reg, code_next;
    logic [TLEN_W-1:0]  tlen_reg, tlen_next;
    logic               tneg_reg, tneg_next;
    logic               tdone_reg, tdone_next;
    logic               tstart_reg, tstart_next;
    logic [VAL_W-1:0]   tval_reg, tval_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic signed [PARAM_W-1:0] store_reg [MAX_PARAMS];
    logic signed [PARAM_W-1:0] store_next [MAX_PARAMS];

    // Result register
    logic               rv_reg, rv_next;
    logic [15:0]        oc_reg, oc_next;
    logic [2:0]         on_reg, on_next;
    logic signed [PARAM_W-1:0] op_reg [NUM_OUT];
    logic signed [PARAM_W-1:0] op_next [NUM_OUT];

    // Pending token folded into the store
    logic                      fin_take;
    logic signed [PARAM_W-1:0] fin_val;
    logic signed [PARAM_W-1:0] fin_store [MAX_PARAMS];
    logic [CNT_W-1:0]          fin_cnt;
    logic [3:0]                digit;
    logic [VAL_W-1:0]          tval_x10;
    logic                      slot_free;

    assign slot_free = !rv_reg || !res_stall;
    assign pop       = q_valid && ((q_head.cls != CLS_LF) || slot_free);

    assign digit    = q_head.ch[3:0];
    assign tval_x10 = (tval_reg << 3) + (tval_reg << 1);

    always_comb
    begin
        fin_take = (tlen_reg != '0) && (cnt_reg < CNT_W'(MAX_PARAMS));
        fin_val  = tneg_reg ? -$signed({1'b0, tval_reg}) : $signed({1'b0, tval_reg});
        fin_cnt  = fin_take ? cnt_reg + 1'b1 : cnt_reg;
        for (int i = 0; i < MAX_PARAMS; i++)
        begin
            fin_store[i] = (fin_take && (cnt_reg == CNT_W'(i))) ? fin_val : store_reg[i];
        end
    end

    always_comb
    begin
        pos_next     = pos_reg;
        stopped_next = stopped_reg;
        code_next    = code_reg;
        tlen_next    = tlen_reg;
        tneg_next    = tneg_reg;
        tdone_next   = tdone_reg;
        tstart_next  = tstart_reg;
        tval_next    = tval_reg;
        cnt_next     = cnt_reg;
        store_next   = store_reg;
        rv_next      = rv_reg && res_stall;
        oc_next      = oc_reg;
        on_next      = on_reg;
        op_next      = op_reg;

        if (pop)
        begin
            case (q_head.cls)
                CLS_LF:
                begin
                    rv_next = 1'b1;
                    oc_next = code_reg;
                    on_next = (int'(fin_cnt) > 7) ? 3'd7 : 3'(fin_cnt);
                    for (int i = 0; i < NUM_OUT; i++)
                    begin
                        op_next[i] = (i < MAX_PARAMS) ? fin_store[i % MAX_PARAMS] : '0;
                    end
                    // clear line
                    pos_next     = '0;
                    stopped_next = 1'b0;
                    code_next    = '0;
                    cnt_next     = '0;
                    for (int i = 0; i < MAX_PARAMS; i++)
                    begin
                        store_next[i] = '0;
                    end
                    tlen_next   = '0;
                    tneg_next   = 1'b0;
                    tdone_next  = 1'b0;
                    tstart_next = 1'b0;
                    tval_next   = '0;
                end
                default:
                begin
                    if (!stopped_reg && (pos_reg != POS_LAST))
                    begin
                        if (q_head.cls == CLS_CR)
                        begin
                            stopped_next = 1'b1;
                        end
                        else
                        begin
                            pos_next = pos_reg + 1'b1;
                            if (pos_reg < POS_W'(2))
                            begin
                                code_next = {code_reg[7:0], q_head.ch};
                            end
                            else if (q_head.cls == CLS_SPACE)
                            begin
                                if (tlen_reg != '0)
                                begin
                                    cnt_next    = fin_cnt;
                                    store_next  = fin_store;
                                    tlen_next   = '0;
                                    tneg_next   = 1'b0;
                                    tdone_next  = 1'b0;
                                    tstart_next = 1'b0;
                                    tval_next   = '0;
                                end
                            end
                            else if (tlen_reg < TLEN_W'(TOKEN_CHARS))
                            begin
                                tlen_next = tlen_reg + 1'b1;
                                if (!tdone_reg)
                                begin
                                    if (!tstart_reg)
                                    begin
                                        if (q_head.cls != CLS_BLANK)
                                        begin
                                            tstart_next = 1'b1;
                                            case (q_head.cls)
                                                CLS_PLUS:  tneg_next  = 1'b0;
                                                CLS_MINUS: tneg_next  = 1'b1;
                                                CLS_DIGIT: tval_next  = VAL_W'(digit);
                                                default:   tdone_next = 1'b1;
                                            endcase
                                        end
                                    end
                                    else if (q_head.cls == CLS_DIGIT)
                                    begin
                                        tval_next = tval_x10 + VAL_W'(digit);
                                    end
                                    else
                                    begin
                                        tdone_next = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            stopped_reg <= 1'b0;
            code_reg    <= '0;
            tlen_reg    <= '0;
            tneg_reg    <= 1'b0;
            tdone_reg   <= 1'b0;
            tstart_reg  <= 1'b0;
            tval_reg    <= '0;
            cnt_reg     <= '0;
            for (int i = 0; i < MAX_PARAMS; i++)
            begin
                store_reg[i] <= '0;
            end
            rv_reg      <= 1'b0;
        end
        else
        begin
            pos_reg     <= pos_next;
            stopped_reg <= stopped_next;
            code_reg    <= code_next;
            tlen_reg    <= tlen_next;
            tneg_reg    <= tneg_next;
            tdone_reg   <= tdone_next;
            tstart_reg  <= tstart_next;
            tval_reg    <= tval_next;
            cnt_reg     <= cnt_next;
            store_reg   <= store_next;
            rv_reg      <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        oc_reg <= oc_next;
        on_reg <= on_next;
        op_reg <= op_next;
    end

    assign res_valid    = rv_reg;
    assign command_code = oc_reg;
    assign param_count  = on_reg;
    assign param_a      = op_reg[0];
    assign param_b      = op_reg[1];
    assign param_c      = op_reg[2];
    assign param_d      = op_reg[3];

endmodule

`default_nettype wire

// ===== rtl/command_line_tokenizer.sv =====
// A line feed byte is written into the queue, then popped and loaded into the
//   result register, which drives res_valid and the result ports.
// Throughput: one byte per cycle unless stalled; set by the parser, taking one
//   queued byte a cycle (multiply-by-ten and add on the token value).
// A line feed waits in the queue only while a previous result is still held.
// Reset (rst_n low, asynchronous) empties the queue, clears all line state.
`default_nettype none

module command_line_tokenizer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // byte channel
    input  wire logic                           rx_valid,
    output logic                                rx_stall,
    input  wire logic [7:0]                     rx_byte,
    // result channel, one beat per line feed
    output logic                                res_valid,
    input  wire logic                           res_stall,
    output logic [15:0]                         command_code,
    output logic [2:0]                          param_count,
    output logic signed [clt_pkg::PARAM_W-1:0]  param_a,
    output logic signed [clt_pkg::PARAM_W-1:0]  param_b,
    output logic signed [clt_pkg::PARAM_W-1:0]  param_c,
    output logic signed [clt_pkg::PARAM_W-1:0]  param_d
);
    import clt_pkg::*;

    // front -> queue
    logic     push;
    q_entry_t push_entry;
    logic     q_full;

    // queue -> back
    logic     q_valid;
    q_entry_t q_head;
    logic     pop;

    // Front: classifies each byte (LF, CR, space, digit, sign, blank, other)
    clt_front u_front (
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .push       (push),
        .push_entry (push_entry),
        .q_full     (q_full)
    );

    // Two-entry queue decouples byte intake from the parser
    clt_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (q_full),
        .pop        (pop),
        .q_valid    (q_valid),
        .q_head     (q_head)
    );

    // Back: line/token state, atoi conversion, result register
    clt_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .pop          (pop),
        .res_valid    (res_valid),
        .res_stall    (res_stall),
        .command_code (command_code),
        .param_count  (param_count),
        .param_a      (param_a),
        .param_b      (param_b),
        .param_c      (param_c),
        .param_d      (param_d)
    );

endmodule

`default_nettype wire
